/* rtl/core/lnsg_pkg.sv */
// Shared widths, reset values and register indexes for the lattice neighbor site generator.
// Depends on nothing; every other source file refers to it, by scoped names or by import.
package lnsg_pkg;

  // Field widths of the channels.
  localparam int unsigned COORD_W = 10;
  localparam int unsigned ORD_W   = 11;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 2;

  // Default clamp for the lattice side.
  localparam int unsigned SIDE_MAX_DEF = 1024;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_LATTICE_KIND = 2'd0,
    REG_PERIODIC     = 2'd1,
    REG_SIZE_X       = 2'd2,
    REG_SIZE_Y       = 2'd3
  } reg_idx_t;

  // Register values after reset.
  localparam logic              RST_LATTICE_KIND = 1'b1;
  localparam logic              RST_PERIODIC     = 1'b0;
  localparam logic [SIZE_W-1:0] RST_SIZE_X       = 11'd16;
  localparam logic [SIZE_W-1:0] RST_SIZE_Y       = 11'd16;

endpackage

/* rtl/core/lnsg_if.sv */
// Valid/ready channel interfaces of the lattice neighbor site generator: query input,
// neighbor result output and configuration write. Depends on lnsg_pkg for field widths.

interface lnsg_in_if;
  logic                          valid;
  logic                          ready;
  logic [lnsg_pkg::COORD_W-1:0]  pos_x;
  logic [lnsg_pkg::COORD_W-1:0]  pos_y;
  logic [lnsg_pkg::ORD_W-1:0]    order;

  modport source (output valid, output pos_x, output pos_y, output order, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input order, output ready);
endinterface

interface lnsg_out_if;
  logic                          valid;
  logic                          ready;
  logic [lnsg_pkg::COORD_W-1:0]  nbr_x;
  logic [lnsg_pkg::COORD_W-1:0]  nbr_y;
  logic                          found;
  logic                          last;

  modport source (output valid, output nbr_x, output nbr_y, output found, output last,
                  input ready);
  modport sink   (input valid, input nbr_x, input nbr_y, input found, input last,
                  output ready);
endinterface

interface lnsg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lnsg_pkg::IDX_W-1:0]    index;
  logic [lnsg_pkg::CFG_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/lattice_neighbor_site_generator.sv */
// Lattice neighbor site generator: pipelined modulo stages and a result serializer.
// Depends on lnsg_pkg and the channel interfaces in lnsg_if.sv.
//
// Usage: a query (pos_x, pos_y, order) is transferred on in_ch. The block lists the
// neighbor sites of that order on the configured chain or square lattice, with open or
// periodic boundaries, one site per transfer on out_ch; last marks the final result of
// a query. If no neighbor exists, one result with found=0 and zero coordinates is sent.
// Configuration registers are written on cfg_ch, which is always ready; writes are
// expected only while no query is in flight.
// A query passes the input stage, the remainder stages and the bundle stage; its results
// then leave through the output register, one per cycle on out_ch while the receiver is
// ready. A query yields one to four results (two on a chain, four on a square when all
// sites exist); the single output register is the limit. The pipeline holds up to six more.
// The pipeline is a register-to-register chain: an input stage, four stages of a
// three-bit-per-stage remainder unit (coordinates and offset modulo the sides), a
// bundle stage that holds the up to four candidate sites, and the output register.
// Reset clears all valid bits and loads the register defaults: square lattice, open
// boundaries, 16 by 16 sites. When the receiver stalls, every stage holds its item and
// in_ch.ready falls once the pipeline is full; nothing is dropped or repeated.
module lattice_neighbor_site_generator #(
  parameter int unsigned SIDE_MAX = lnsg_pkg::SIDE_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lnsg_in_if.sink   in_ch,
  lnsg_out_if.source out_ch,
  lnsg_cfg_if.sink  cfg_ch
);

  localparam int unsigned CW  = lnsg_pkg::COORD_W;
  localparam int unsigned OW  = lnsg_pkg::ORD_W;
  localparam int unsigned SW  = lnsg_pkg::SIZE_W;
  localparam int unsigned SIZE_LIM = (1 << SW) - 1;
  localparam int unsigned CLAMP_I  = (SIDE_MAX < SIZE_LIM) ? SIDE_MAX : SIZE_LIM;
  localparam logic [SW-1:0] SIDE_CLAMP = SW'(CLAMP_I);

  // Remainder unit geometry: dividend width covers the order and a padding bit.
  localparam int unsigned DIV_W      = OW + 1;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int unsigned NST        = DIV_STAGES + 1;
  localparam int unsigned SLOTS      = 4;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [OW-1:0] k;
    logic [SW-1:0] nx;
    logic [SW-1:0] ny;
    logic          chain;
    logic          odd;
  } item_t;

  typedef struct packed {
    logic [SW-1:0] rpx;
    logic [SW-1:0] rpy;
    logic [SW-1:0] rkx;
    logic [SW-1:0] rky;
  } rem_t;

  typedef struct packed {
    logic [CW-1:0] plus;
    logic [CW-1:0] minus;
    logic [CW-1:0] zero;
    logic          ok_plus;
    logic          ok_minus;
    logic          ok_zero;
  } axis_t;

  // Side clamp: zero acts as one, above the limit acts as the limit.
  function automatic logic [SW-1:0] side_of(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == '0) begin
      r = SW'(1);
    end else if (s > SIDE_CLAMP) begin
      r = SIDE_CLAMP;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // One restoring remainder step: shift in a dividend bit, subtract the side if it fits.
  function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] rem, input logic b,
                                             input logic [SW-1:0] d);
    logic [SW:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SW-1:0];
  endfunction

  // Candidate coordinates along one axis for the plus, minus and zero offsets.
  function automatic axis_t axis_sites(input logic per, input logic [CW-1:0] p,
                                       input logic [OW-1:0] k, input logic [SW-1:0] n,
                                       input logic [SW-1:0] rp, input logic [SW-1:0] rk);
    axis_t a;
    logic [SW:0] sum;
    logic [SW:0] dif;
    logic [SW:0] osum;
    if (per) begin
      sum = {1'b0, rp} + {1'b0, rk};
      if (sum >= {1'b0, n}) begin
        sum = sum - {1'b0, n};
      end
      dif = {1'b0, rp} - {1'b0, rk};
      if (dif[SW]) begin
        dif = dif + {1'b0, n};
      end
      a.plus     = sum[CW-1:0];
      a.minus    = dif[CW-1:0];
      a.zero     = rp[CW-1:0];
      a.ok_plus  = 1'b1;
      a.ok_minus = 1'b1;
      a.ok_zero  = 1'b1;
    end else begin
      osum       = {{(SW+1-CW){1'b0}}, p} + {1'b0, k};
      dif        = {{(SW+1-CW){1'b0}}, p} - {1'b0, k};
      a.plus     = osum[CW-1:0];
      a.minus    = dif[CW-1:0];
      a.zero     = p;
      a.ok_plus  = osum < {1'b0, n};
      // A query site beyond the side can still land beyond it after stepping down.
      a.ok_minus = !dif[SW] && (dif < {1'b0, n});
      a.ok_zero  = {{(SW-CW){1'b0}}, p} < n;
    end
    return a;
  endfunction

  // Configuration registers.
  logic          lattice_kind_r;
  logic          periodic_r;
  logic [SW-1:0] size_x_r;
  logic [SW-1:0] size_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_kind_r <= lnsg_pkg::RST_LATTICE_KIND;
      periodic_r     <= lnsg_pkg::RST_PERIODIC;
      size_x_r       <= lnsg_pkg::RST_SIZE_X;
      size_y_r       <= lnsg_pkg::RST_SIZE_Y;
    end else if (cfg_ch.valid) begin
      unique case (lnsg_pkg::reg_idx_t'(cfg_ch.index))
        lnsg_pkg::REG_LATTICE_KIND: lattice_kind_r <= cfg_ch.data[0];
        lnsg_pkg::REG_PERIODIC:     periodic_r     <= cfg_ch.data[0];
        lnsg_pkg::REG_SIZE_X:       size_x_r       <= cfg_ch.data[SW-1:0];
        lnsg_pkg::REG_SIZE_Y:       size_y_r       <= cfg_ch.data[SW-1:0];
      endcase
    end
  end

  // Pipeline stage storage; stage 0 is the input stage, the rest run the remainder unit.
  logic  st_v_r    [NST];
  item_t st_item_r [NST];
  rem_t  st_rem_r  [NST];
  logic [NST:0] rdy;

  logic bundle_ready;
  assign rdy[NST] = bundle_ready;

  for (genvar j = 0; j < NST; j++) begin : g_rdy
    assign rdy[j] = !st_v_r[j] || rdy[j+1];
  end

  assign in_ch.ready = rdy[0];

  // Input stage: decode the offset and clamp the sides.
  item_t in_item;
  logic [OW-1:0] half_ord;

  always_comb begin
    half_ord        = {1'b0, in_ch.order[OW-1:1]};
    in_item.px      = in_ch.pos_x;
    in_item.py      = in_ch.pos_y;
    in_item.chain   = !lattice_kind_r;
    in_item.odd     = in_ch.order[0];
    in_item.nx      = side_of(size_x_r);
    in_item.ny      = side_of(size_y_r);
    if (!lattice_kind_r) begin
      in_item.k = in_ch.order;
    end else if (in_ch.order[0]) begin
      in_item.k = half_ord + OW'(1);
    end else begin
      in_item.k = half_ord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      st_v_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy[0]) begin
      st_item_r[0] <= in_item;
      st_rem_r[0]  <= '0;
    end
  end

  // Remainder stages: each takes three dividend bits of all four remainders.
  for (genvar j = 1; j < NST; j++) begin : g_div
    rem_t              rem_nxt;
    logic [DIV_W-1:0]  dpx;
    logic [DIV_W-1:0]  dpy;
    logic [DIV_W-1:0]  dk;

    always_comb begin
      int idx;
      dpx     = {{(DIV_W-CW){1'b0}}, st_item_r[j-1].px};
      dpy     = {{(DIV_W-CW){1'b0}}, st_item_r[j-1].py};
      dk      = {{(DIV_W-OW){1'b0}}, st_item_r[j-1].k};
      rem_nxt = st_rem_r[j-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        idx = DIV_W - 1 - (DIV_STEPS * (j - 1) + s);
        rem_nxt.rpx = mod_step(rem_nxt.rpx, dpx[idx], st_item_r[j-1].nx);
        rem_nxt.rpy = mod_step(rem_nxt.rpy, dpy[idx], st_item_r[j-1].ny);
        rem_nxt.rkx = mod_step(rem_nxt.rkx, dk[idx], st_item_r[j-1].nx);
        rem_nxt.rky = mod_step(rem_nxt.rky, dk[idx], st_item_r[j-1].ny);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        st_v_r[j] <= st_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_v_r[j-1] && rdy[j]) begin
        st_item_r[j] <= st_item_r[j-1];
        st_rem_r[j]  <= rem_nxt;
      end
    end
  end

  // Site assembly from the final remainders.
  axis_t ax;
  axis_t ay;
  logic [CW-1:0]    cand_x [SLOTS];
  logic [CW-1:0]    cand_y [SLOTS];
  logic [SLOTS-1:0] cand_ok;

  always_comb begin
    ax = axis_sites(periodic_r, st_item_r[NST-1].px, st_item_r[NST-1].k,
                    st_item_r[NST-1].nx, st_rem_r[NST-1].rpx, st_rem_r[NST-1].rkx);
    ay = axis_sites(periodic_r, st_item_r[NST-1].py, st_item_r[NST-1].k,
                    st_item_r[NST-1].ny, st_rem_r[NST-1].rpy, st_rem_r[NST-1].rky);
    for (int s = 0; s < SLOTS; s++) begin
      cand_y[s] = '0;
    end
    if (st_item_r[NST-1].chain) begin
      // Chain: minus side first, then plus side.
      cand_x[0] = ax.minus;
      cand_x[1] = ax.plus;
      cand_x[2] = ax.zero;
      cand_x[3] = ax.zero;
      cand_ok   = {1'b0, 1'b0, ax.ok_plus, ax.ok_minus};
    end else if (st_item_r[NST-1].odd) begin
      // Axial sites: +x, -x, +y, -y.
      cand_x[0] = ax.plus;   cand_y[0] = ay.zero;
      cand_x[1] = ax.minus;  cand_y[1] = ay.zero;
      cand_x[2] = ax.zero;   cand_y[2] = ay.plus;
      cand_x[3] = ax.zero;   cand_y[3] = ay.minus;
      cand_ok   = {ax.ok_zero & ay.ok_minus, ax.ok_zero & ay.ok_plus,
                   ax.ok_minus & ay.ok_zero, ax.ok_plus & ay.ok_zero};
    end else begin
      // Diagonal sites: (+,+), (-,+), (+,-), (-,-).
      cand_x[0] = ax.plus;   cand_y[0] = ay.plus;
      cand_x[1] = ax.minus;  cand_y[1] = ay.plus;
      cand_x[2] = ax.plus;   cand_y[2] = ay.minus;
      cand_x[3] = ax.minus;  cand_y[3] = ay.minus;
      cand_ok   = {ax.ok_minus & ay.ok_minus, ax.ok_plus & ay.ok_minus,
                   ax.ok_minus & ay.ok_plus, ax.ok_plus & ay.ok_plus};
    end
  end

  // Bundle stage: holds the candidate sites and the mask of results still to send.
  logic [CW-1:0]    bx_r [SLOTS];
  logic [CW-1:0]    by_r [SLOTS];
  logic             bfound_r;
  logic [SLOTS-1:0] pend_r;
  logic [SLOTS-1:0] pend_after;
  logic [1:0]       sel;
  logic             out_free;
  logic             emit;
  logic             bundle_load;

  logic             out_valid_r;
  logic [CW-1:0]    out_x_r;
  logic [CW-1:0]    out_y_r;
  logic             out_found_r;
  logic             out_last_r;

  always_comb begin
    if (pend_r[0]) begin
      sel = 2'd0;
    end else if (pend_r[1]) begin
      sel = 2'd1;
    end else if (pend_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign pend_after   = pend_r & (pend_r - SLOTS'(1));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign emit         = out_free && (pend_r != '0);
  assign bundle_ready = (pend_r == '0) || (emit && (pend_after == '0));
  assign bundle_load  = st_v_r[NST-1] && bundle_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (bundle_load) begin
      pend_r <= (cand_ok != '0) ? cand_ok : SLOTS'(1);
    end else if (emit) begin
      pend_r <= pend_after;
    end
  end

  // With no neighbor, slot zero carries the empty result.
  always_ff @(posedge clk) begin
    if (bundle_load) begin
      bfound_r <= (cand_ok != '0);
      for (int s = 0; s < SLOTS; s++) begin
        bx_r[s] <= (cand_ok != '0) ? cand_x[s] : '0;
        by_r[s] <= (cand_ok != '0) ? cand_y[s] : '0;
      end
    end
  end

  // Output register: one transfer per cycle while results are pending and the receiver is ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r     <= bx_r[sel];
      out_y_r     <= by_r[sel];
      out_found_r <= bfound_r;
      out_last_r  <= (pend_after == '0);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.nbr_x = out_x_r;
  assign out_ch.nbr_y = out_y_r;
  assign out_ch.found = out_found_r;
  assign out_ch.last  = out_last_r;

endmodule

/* rtl/core/lnsg_checker.sv */
// Port-level assertions for the lattice neighbor site generator, bound to the top level.
// Depends on lnsg_pkg for field widths and on lattice_neighbor_site_generator's ports.
module lnsg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lnsg_pkg::COORD_W-1:0]  nbr_x,
  input logic [lnsg_pkg::COORD_W-1:0]  nbr_y,
  input logic                          found,
  input logic                          last,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // A result held by a stalled receiver keeps its content until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(nbr_x) && $stable(nbr_y) &&
                               $stable(found) && $stable(last))
    else $error("result changed while stalled");

  // Reset empties the pipeline: no result pending and the input open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // An empty result is the only result of its query and carries zero coordinates.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> last && (nbr_x == '0) && (nbr_y == '0))
    else $error("malformed empty result");

  // Configuration writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind lattice_neighbor_site_generator lnsg_checker u_lnsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .nbr_x     (out_ch.nbr_x),
  .nbr_y     (out_ch.nbr_y),
  .found     (out_ch.found),
  .last      (out_ch.last),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);

/* sim/lnsg_site_checker.sv */
// Checker for the lattice neighbor site generator: it watches the query, result and
// register write channels, predicts the neighbor sites and compares them field by field.
// Depends on lnsg_pkg and the channel interfaces in lnsg_if.sv.
module lnsg_site_checker
  import lnsg_pkg::*;
#(
  parameter int unsigned SIDE_MAX = SIDE_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lnsg_in_if   in_ch,
  lnsg_out_if  out_ch,
  lnsg_cfg_if  cfg_ch,
  output int   mismatch_count,
  output int   pending_sites,
  output int   queries_seen,
  output int   sites_checked,
  output int   empty_results
);

  typedef struct packed {
    logic [COORD_W-1:0] nbr_x;
    logic [COORD_W-1:0] nbr_y;
    logic               found;
    logic               last;
  } nbr_site_t;

  // Shadow copy of the lattice registers, updated on every register write transfer.
  logic              square_q;
  logic              periodic_q;
  logic [SIZE_W-1:0] size_x_q;
  logic [SIZE_W-1:0] size_y_q;

  // Neighbor sites still owed by the block, oldest first.
  nbr_site_t owed_sites[$];

  int mismatches;
  int queries;
  int checked;
  int empties;

  // A side of zero behaves as one site, a side above the limit as the limit.
  function automatic int clamp_side(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIDE_MAX) return int'(SIDE_MAX);
    return int'(s);
  endfunction

  // Work out the neighbor sites of one query and append them to the owed list.
  function automatic void list_neighbor_sites(input logic [COORD_W-1:0] px,
                                              input logic [COORD_W-1:0] py,
                                              input logic [ORD_W-1:0]   ord);
    int        ox[4];
    int        oy[4];
    int        count;
    int        k;
    int        wx;
    int        wy;
    int        x;
    int        y;
    int        i;
    nbr_site_t site;
    nbr_site_t batch[$];

    wx = clamp_side(size_x_q);
    wy = clamp_side(size_y_q);

    // Offsets: the order itself on a chain, axial or diagonal steps on a square.
    if (!square_q) begin
      ox[0] = -int'(ord);
      oy[0] = 0;
      ox[1] = int'(ord);
      oy[1] = 0;
      count = 2;
    end else if (ord[0]) begin
      k = (int'(ord) + 1) / 2;
      ox = '{k, -k, 0, 0};
      oy = '{0, 0, k, -k};
      count = 4;
    end else begin
      k = int'(ord) / 2;
      ox = '{k, -k, k, -k};
      oy = '{k, k, -k, -k};
      count = 4;
    end

    // Wrap on periodic boundaries, drop sites outside on open ones.
    for (i = 0; i < count; i++) begin
      x = int'(px) + ox[i];
      y = square_q ? int'(py) + oy[i] : 0;
      if (periodic_q) begin
        x = x % wx;
        if (x < 0) x += wx;
        if (square_q) begin
          y = y % wy;
          if (y < 0) y += wy;
        end
      end else if (x < 0 || x >= wx || (square_q && (y < 0 || y >= wy))) begin
        continue;
      end
      site.nbr_x = COORD_W'(x);
      site.nbr_y = COORD_W'(y);
      site.found = 1'b1;
      site.last  = 1'b0;
      batch = {batch, site};
    end

    // A query without neighbors still yields one empty result.
    if (batch.size() == 0) begin
      site = '0;
      batch = {batch, site};
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[j]) owed_sites = {owed_sites, batch[j]};
  endfunction

  // Per edge: compare a result transfer, predict a query transfer, track register writes.
  always @(posedge clk) begin
    nbr_site_t want;
    if (!rst_n) begin
      square_q   = RST_LATTICE_KIND;
      periodic_q = RST_PERIODIC;
      size_x_q   = RST_SIZE_X;
      size_y_q   = RST_SIZE_Y;
      owed_sites.delete();
      mismatches = 0;
      queries    = 0;
      checked    = 0;
      empties    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_sites.size() == 0) begin
          $error("Neighbor result with no query waiting: nbr_x %0d nbr_y %0d found %0d last %0d",
                 out_ch.nbr_x, out_ch.nbr_y, out_ch.found, out_ch.last);
          mismatches++;
        end else begin
          want = owed_sites.pop_front();
          if (out_ch.nbr_x !== want.nbr_x) begin
            $error("nbr_x mismatch: expected %0d, actual %0d", want.nbr_x, out_ch.nbr_x);
            mismatches++;
          end
          if (out_ch.nbr_y !== want.nbr_y) begin
            $error("nbr_y mismatch: expected %0d, actual %0d", want.nbr_y, out_ch.nbr_y);
            mismatches++;
          end
          if (out_ch.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, out_ch.found);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_ch.last);
            mismatches++;
          end
          if (!want.found) empties++;
          checked++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        list_neighbor_sites(in_ch.pos_x, in_ch.pos_y, in_ch.order);
        queries++;
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_LATTICE_KIND: square_q   = cfg_ch.data[0];
          REG_PERIODIC:     periodic_q = cfg_ch.data[0];
          REG_SIZE_X:       size_x_q   = cfg_ch.data[SIZE_W-1:0];
          default:          size_y_q   = cfg_ch.data[SIZE_W-1:0];
        endcase
      end
    end

    mismatch_count <= mismatches;
    pending_sites  <= owed_sites.size();
    queries_seen   <= queries;
    sites_checked  <= checked;
    empty_results  <= empties;
  end

endmodule

/* sim/lattice_neighbor_site_generator_test.sv */
// Testbench top for the lattice neighbor site generator: clock, reset, query and register
// stimulus, a stalling result receiver, a watchdog and the verdict.
// Depends on lnsg_pkg, lnsg_if.sv, the block itself and lnsg_site_checker.
module lattice_neighbor_site_generator_test;
  import lnsg_pkg::*;

  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned IDLE_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst_n;

  lnsg_in_if  in_ch ();
  lnsg_out_if out_ch ();
  lnsg_cfg_if cfg_ch ();

  int          mismatch_count;
  int          pending_sites;
  int          queries_seen;
  int          sites_checked;
  int          empty_results;
  int unsigned queries_sent;
  int unsigned idle_cycles;
  int unsigned settings_run;

  // Lattice settings in force, used to aim the random queries.
  logic              square_set;
  logic [SIZE_W-1:0] size_x_set;
  logic [SIZE_W-1:0] size_y_set;

  lattice_neighbor_site_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lnsg_site_checker site_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_sites  (pending_sites),
    .queries_seen   (queries_seen),
    .sites_checked  (sites_checked),
    .empty_results  (empty_results)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run when no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: stretches of steady, random and sparse readiness, and two long
  // hold-offs while queries keep coming so that the pipeline fills and stalls its input.
  initial begin
    int unsigned stretch;
    int unsigned style;
    int unsigned holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done < 2 && queries_seen >= (holds_done == 0 ? 40 : 220)) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stretch = $urandom_range(8, 40);
      style   = $urandom_range(3);
      repeat (stretch) begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(1) == 1);
          2:       out_ch.ready <= ($urandom_range(3) == 0);
          default: out_ch.ready <= ~out_ch.ready;
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one query and hold it until the block takes it; valid stays high afterwards.
  task automatic offer_query(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy,
                             input logic [ORD_W-1:0] qo);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= qx;
    in_ch.pos_y <= qy;
    in_ch.order <= qo;
    do @(posedge clk); while (!in_ch.ready);
    queries_sent++;
  endtask

  // Random queries in bursts; positions mostly inside the lattice and orders mostly
  // within reach of it, the rest over the full field ranges.
  task automatic random_queries(input int unsigned count);
    int unsigned        left;
    int unsigned        burst;
    int unsigned        gap;
    int unsigned        wx;
    int unsigned        wy;
    int unsigned        reach;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [ORD_W-1:0]   qo;
    wx = (size_x_set == '0) ? 1 : (size_x_set > SIDE_MAX_DEF ? SIDE_MAX_DEF : size_x_set);
    wy = (size_y_set == '0) ? 1 : (size_y_set > SIDE_MAX_DEF ? SIDE_MAX_DEF : size_y_set);
    reach = square_set ? 2 * (wx > wy ? wx : wy) + 1 : wx + 1;
    if (reach > 2047) reach = 2047;
    left = count;
    while (left != 0) begin
      burst = ($urandom_range(3) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      while (burst != 0 && left != 0) begin
        qx = ($urandom_range(7) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(wx - 1));
        qy = ($urandom_range(7) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(wy - 1));
        case ($urandom_range(9))
          0, 1:    qo = ORD_W'($urandom);
          2:       qo = '0;
          default: qo = ORD_W'($urandom_range(reach, 1));
        endcase
        offer_query(qx, qy, qo);
        burst--;
        left--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every query has been seen and fully answered.
  task automatic drain_queries();
    in_ch.valid <= 1'b0;
    while (queries_seen != queries_sent || pending_sites != 0) @(posedge clk);
  endtask

  // Write all four lattice registers back to back, valid held high across them.
  task automatic program_lattice(input logic square, input logic wrap_on,
                                 input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy);
    reg_idx_t r;
    r = r.first();
    repeat (4) begin
      cfg_ch.index <= r;
      case (r)
        REG_LATTICE_KIND: cfg_ch.data <= CFG_W'(square);
        REG_PERIODIC:     cfg_ch.data <= CFG_W'(wrap_on);
        REG_SIZE_X:       cfg_ch.data <= sx;
        default:          cfg_ch.data <= sy;
      endcase
      cfg_ch.valid <= 1'b1;
      do @(posedge clk); while (!cfg_ch.ready);
      r = r.next();
    end
    cfg_ch.valid <= 1'b0;
    square_set = square;
    size_x_set = sx;
    size_y_set = sy;
    settings_run++;
  endtask

  // Main sequence: reset, then one lattice setting after another.
  initial begin
    queries_sent = 0;
    settings_run = 1;
    square_set   = RST_LATTICE_KIND;
    size_x_set   = RST_SIZE_X;
    size_y_set   = RST_SIZE_Y;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.pos_x  <= '0;
    in_ch.pos_y  <= '0;
    in_ch.order  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_LATTICE_KIND;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, a 16 by 16 open square: corners, order zero, the largest
    // fields, a query site outside the lattice and an order too large for any neighbor.
    offer_query(10'd0, 10'd0, 11'd1);
    offer_query(10'd0, 10'd0, 11'd2);
    offer_query(10'd15, 10'd15, 11'd1);
    offer_query(10'd15, 10'd15, 11'd2);
    offer_query(10'd6, 10'd9, 11'd0);
    offer_query(10'd1023, 10'd1023, 11'd2047);
    offer_query(10'd20, 10'd5, 11'd1);
    offer_query(10'd7, 10'd7, 11'd31);
    random_queries(60);
    drain_queries();

    // Open chain with a length above the limit and a height of zero.
    program_lattice(1'b0, 1'b0, 11'd2047, 11'd0);
    offer_query(10'd0, 10'd0, 11'd1);
    offer_query(10'd1023, 10'd1023, 11'd1);
    offer_query(10'd512, 10'd3, 11'd0);
    offer_query(10'd0, 10'd0, 11'd2047);
    random_queries(45);
    drain_queries();

    // Periodic chain with a length of zero: every site folds onto one.
    program_lattice(1'b0, 1'b1, 11'd0, 11'd1);
    offer_query(10'd5, 10'd5, 11'd3);
    offer_query(10'd1023, 10'd0, 11'd2047);
    random_queries(25);
    drain_queries();

    // Periodic square at the full side.
    program_lattice(1'b1, 1'b1, 11'd1024, 11'd1024);
    offer_query(10'd0, 10'd0, 11'd2047);
    offer_query(10'd1023, 10'd1023, 11'd2046);
    offer_query(10'd0, 10'd1023, 11'd1);
    random_queries(45);
    drain_queries();

    // Small periodic square, where wrapped sites coincide.
    program_lattice(1'b1, 1'b1, 11'd3, 11'd5);
    offer_query(10'd2, 10'd4, 11'd1);
    offer_query(10'd1, 10'd1, 11'd4);
    offer_query(10'd700, 10'd900, 11'd5);
    random_queries(60);
    drain_queries();

    // One-site open square: mostly empty answers.
    program_lattice(1'b1, 1'b0, 11'd1, 11'd0);
    offer_query(10'd0, 10'd0, 11'd0);
    offer_query(10'd0, 10'd0, 11'd1);
    offer_query(10'd3, 10'd0, 11'd0);
    random_queries(20);
    drain_queries();

    // Wide open square, height above the limit.
    program_lattice(1'b1, 1'b0, 11'd1024, 11'd2047);
    offer_query(10'd1023, 10'd0, 11'd1);
    random_queries(45);
    drain_queries();

    // Short periodic chain.
    program_lattice(1'b0, 1'b1, 11'd7, 11'd16);
    random_queries(45);
    drain_queries();

    // Give stray results time to show up before the verdict.
    repeat (12) @(posedge clk);
    $display("Checked %0d queries and %0d neighbor results (%0d empty) over %0d settings.",
             queries_seen, sites_checked, empty_results, settings_run);
    $display("Settings spanned chain and square, open and periodic, sides from 0 to 2047.");
    if (mismatch_count == 0 && pending_sites == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* lattice_neighbor_site_generator.f */
rtl/core/lnsg_pkg.sv
rtl/core/lnsg_if.sv
rtl/core/lattice_neighbor_site_generator.sv
rtl/core/lnsg_checker.sv
sim/lnsg_site_checker.sv
sim/lattice_neighbor_site_generator_test.sv
